// File: rtl/klv_essence_deframer_unit_defines.svh
// Assertion macros shared by the deframer RTL.
// Included by files that carry concurrent checks; relies on clk_i and rst_ni in scope.
`ifndef KLV_ESSENCE_DEFRAMER_UNIT_DEFINES_SVH
`define KLV_ESSENCE_DEFRAMER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define KLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define KLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KLV_ASSERT(lbl, prop, msg)
`define KLV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/klvdf_pkg.sv
// Types, constants and helpers for the KLV essence deframer.
// No dependencies; imported by klvdf_stream_match and the top level.
`timescale 1ns / 1ps
`default_nettype none
package klvdf_pkg;

  localparam int NUM_STREAMS   = 4;
  localparam int KEY_LEN       = 16;
  localparam int PREFIX_LEN    = 7;
  localparam int ID_START      = 12;
  localparam int MAX_BER_BYTES = 8;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BER_ERR = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ACTIVE   = 3'd0,
    CFG_STREAM_0 = 3'd1,
    CFG_STREAM_1 = 3'd2,
    CFG_STREAM_2 = 3'd3,
    CFG_STREAM_3 = 3'd4
  } cfg_idx_e;

  // Stream lookup result
  typedef struct packed {
    logic       found;
    logic [1:0] index;
  } match_t;

  // Essence element key prefix, byte by byte
  function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h06;
      4'd1:    val = 8'h0e;
      4'd2:    val = 8'h2b;
      4'd3:    val = 8'h34;
      4'd4:    val = 8'h01;
      4'd5:    val = 8'h02;
      4'd6:    val = 8'h01;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// File: rtl/klvdf_stream_match.sv
// Stream id lookup: lowest active stream whose id equals the key track word.
// Depends on klvdf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module klvdf_stream_match (
  input  logic [2:0]           active_streams_i,
  input  logic [3:0][31:0]     stream_id_i,
  input  logic [31:0]          track_word_i,
  output klvdf_pkg::match_t    match_o
);
  import klvdf_pkg::*;

  localparam logic [2:0] NumStreamsW = 3'(NUM_STREAMS);

  logic [2:0] n_active;

  // Clamp active count to the number of id registers
  assign n_active = (active_streams_i > NumStreamsW) ? NumStreamsW : active_streams_i;

  // Priority search, lowest index wins
  always_comb begin
    match_o = '0;
    for (int i = NUM_STREAMS - 1; i >= 0; i--) begin
      if ((3'(i) < n_active) && (stream_id_i[i] == track_word_i)) begin
        match_o.found = 1'b1;
        match_o.index = 2'(i);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/klv_essence_deframer_unit.sv
// KLV essence deframer: one byte per cycle in, at most one result item per byte out.
// A result item is registered and valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; in_ready_o drops only while a result item waits.
// The 64-bit length counter decrement is combinational and sets the per-byte path.
// Reset (rst_ni low, async): expects a key byte, output empty, config registers zero.
// After a length error or unknown stream the block takes and drops bytes until reset.
`timescale 1ns / 1ps
`default_nettype none
`include "klv_essence_deframer_unit_defines.svh"
module klv_essence_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  // result items out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  stream_sel_o,
  output logic        packet_end_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import klvdf_pkg::*;

  typedef enum logic [2:0] {
    PH_KEY, PH_BER_FIRST, PH_BER_LONG, PH_PAYLOAD, PH_SKIP, PH_HALT
  } phase_e;

  localparam logic [3:0] KeyLast   = 4'(KEY_LEN - 1);
  localparam logic [3:0] PrefixEnd = 4'(PREFIX_LEN);
  localparam logic [3:0] IdStart   = 4'(ID_START);
  localparam logic [6:0] MaxBer    = 7'(MAX_BER_BYTES);

  phase_e      phase_q, phase_d;
  logic [3:0]  key_count_q, key_count_d;
  logic        prefix_q, prefix_d;
  logic [31:0] track_q, track_d;
  logic [3:0]  ber_left_q, ber_left_d;
  logic [63:0] rem_q, rem_d;
  logic [1:0]  cur_stream_q, cur_stream_d;
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [1:0]  sidx_q, sidx_d;
  logic        end_q, end_d;

  logic [2:0]       active_q;
  logic [3:0][31:0] stream_id_q;
  match_t           match;
  logic             in_acc;
  logic             emit;
  logic             len_done;
  logic [63:0]      len_val;
  logic [63:0]      rem_dec;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      stream_id_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ACTIVE:   active_q       <= cfg_data_i[2:0];
        CFG_STREAM_0: stream_id_q[0] <= cfg_data_i;
        CFG_STREAM_1: stream_id_q[1] <= cfg_data_i;
        CFG_STREAM_2: stream_id_q[2] <= cfg_data_i;
        CFG_STREAM_3: stream_id_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  klvdf_stream_match u_match (
    .active_streams_i (active_q),
    .stream_id_i      (stream_id_q),
    .track_word_i     (track_q),
    .match_o          (match)
  );

  assign rem_dec = rem_q - 64'd1;

  // Per-byte parse
  always_comb begin
    phase_d      = phase_q;
    key_count_d  = key_count_q;
    prefix_d     = prefix_q;
    track_d      = track_q;
    ber_left_d   = ber_left_q;
    rem_d        = rem_q;
    cur_stream_d = cur_stream_q;
    emit         = 1'b0;
    kind_d       = KIND_PAYLOAD;
    byte_d       = 8'd0;
    sidx_d       = 2'd0;
    end_d        = 1'b0;
    len_done     = 1'b0;
    len_val      = 64'd0;

    case (phase_q)
      PH_KEY: begin
        if (key_count_q < PrefixEnd) begin
          prefix_d = ((key_count_q == 4'd0) ? 1'b1 : prefix_q) &&
                     (in_byte_i == prefix_byte(key_count_q));
        end
        if (key_count_q >= IdStart) begin
          track_d = {track_q[23:0], in_byte_i};
        end
        key_count_d = key_count_q + 4'd1;
        if (key_count_q == KeyLast) begin
          phase_d = PH_BER_FIRST;
        end
      end
      PH_BER_FIRST: begin
        rem_d = 64'd0;
        if (!in_byte_i[7]) begin
          len_done = 1'b1;
          len_val  = {57'd0, in_byte_i[6:0]};
        end else if (in_byte_i[6:0] > MaxBer) begin
          phase_d = PH_HALT;
          emit    = 1'b1;
          kind_d  = KIND_BER_ERR;
        end else if (in_byte_i[6:0] == 7'd0) begin
          len_done = 1'b1;
        end else begin
          ber_left_d = in_byte_i[3:0];
          phase_d    = PH_BER_LONG;
        end
      end
      PH_BER_LONG: begin
        ber_left_d = ber_left_q - 4'd1;
        rem_d      = {rem_q[55:0], in_byte_i};
        if (ber_left_q == 4'd1) begin
          len_done = 1'b1;
          len_val  = {rem_q[55:0], in_byte_i};
        end
      end
      PH_PAYLOAD: begin
        rem_d  = rem_dec;
        emit   = 1'b1;
        kind_d = KIND_PAYLOAD;
        byte_d = in_byte_i;
        sidx_d = cur_stream_q;
        end_d  = (rem_q == 64'd1);
        if (rem_q == 64'd1) begin
          phase_d = PH_KEY;
        end
      end
      PH_SKIP: begin
        rem_d = rem_dec;
        if (rem_q == 64'd1) begin
          phase_d = PH_KEY;
        end
      end
      default: phase_d = PH_HALT;
    endcase

    // Length field complete: route the packet body
    if (len_done) begin
      rem_d = len_val;
      if (!prefix_q) begin
        phase_d = (len_val == 64'd0) ? PH_KEY : PH_SKIP;
      end else if (!match.found) begin
        phase_d = PH_HALT;
        emit    = 1'b1;
        kind_d  = KIND_UNKNOWN;
      end else begin
        cur_stream_d = match.index;
        if (len_val == 64'd0) begin
          phase_d = PH_KEY;
          emit    = 1'b1;
          kind_d  = KIND_EMPTY;
          sidx_d  = match.index;
          end_d   = 1'b1;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
    end

    // Output register: load on accept, drain when taken
    if (in_acc) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Parser state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_KEY;
      key_count_q  <= '0;
      prefix_q     <= 1'b1;
      track_q      <= '0;
      ber_left_q   <= '0;
      rem_q        <= '0;
      cur_stream_q <= '0;
      out_valid_q  <= 1'b0;
      kind_q       <= KIND_PAYLOAD;
      byte_q       <= '0;
      sidx_q       <= '0;
      end_q        <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q      <= phase_d;
        key_count_q  <= key_count_d;
        prefix_q     <= prefix_d;
        track_q      <= track_d;
        ber_left_q   <= ber_left_d;
        rem_q        <= rem_d;
        cur_stream_q <= cur_stream_d;
        if (emit) begin
          kind_q <= kind_d;
          byte_q <= byte_d;
          sidx_q <= sidx_d;
          end_q  <= end_d;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign payload_byte_o = byte_q;
  assign stream_sel_o   = sidx_q;
  assign packet_end_o   = end_q;

  // Checks
  `KLV_ASSERT_NEXT(a_halt_silent, in_acc && phase_q == PH_HALT, !out_valid_q,
    "halted block produced a result item")
  `KLV_ASSERT(a_err_fields, out_valid_q && (kind_q == KIND_BER_ERR || kind_q == KIND_UNKNOWN)
    |-> !end_q && byte_q == 8'd0 && sidx_q == 2'd0, "error item with nonzero fields")
  `KLV_ASSERT(a_err_halts, out_valid_q && (kind_q == KIND_BER_ERR || kind_q == KIND_UNKNOWN)
    |-> phase_q == PH_HALT, "error item without halt")
  `KLV_ASSERT(a_key_count, key_count_q != 4'd0 |-> phase_q == PH_KEY,
    "key counter running outside key phase")
  `KLV_ASSERT(a_ber_left, phase_q == PH_BER_LONG |-> ber_left_q != 4'd0 &&
    ber_left_q <= 4'(MAX_BER_BYTES), "length byte count out of range")

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for klv_essence_deframer_unit: KLV byte stream in, result items out.
// Depends on klvdf_pkg (result kinds, register indexes, key constants) and the unit's RTL.
`timescale 1ns / 1ps
module tb_top;
  import klvdf_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 4;     // result is registered in the cycle after its byte is taken
  localparam int END_CYCLES    = 12;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int PHASE_BYTES   = 100;
  localparam int NUM_PHASES    = 5;
  localparam int DIR_ROWS      = 7;
  localparam int TAIL_BYTES    = 20;
  localparam int SHORT_FORM    = -1;    // length coded in one byte, top bit clear

  // Essence element key lead, first byte in the top bits
  localparam logic [55:0] ESSENCE_LEAD = 56'h06_0e_2b_34_01_02_01;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [1:0] sidx;
    logic       last;
  } dfr_result_t;

  // One directed packet
  typedef struct packed {
    bit          essence;
    logic [31:0] track;
    int          len;
    int          lcount;   // SHORT_FORM, or long-form count (above 8 is illegal)
    int          fill;     // payload byte value, negative for random
    bit          typed;    // last byte carries the expectation below
    dfr_result_t want;
  } dir_row_t;

  typedef enum logic [2:0] {
    ST_KEY, ST_LEN0, ST_LEN_MORE, ST_BODY, ST_SKIP, ST_HALT
  } dp_state_e;

  // DUT connections
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte    = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic [1:0]  res_sidx;
  logic        res_last;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;

  // Typed expectation that travels with the byte on the input channel
  logic        note_valid = 1'b0;
  dfr_result_t note_r     = '0;

  // Receiver controls
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  // Deframer model state and register copy
  dp_state_e        dp_state     = ST_KEY;
  int               dp_key_pos   = 0;
  bit               dp_is_ess    = 1'b1;
  logic [31:0]      dp_track     = '0;
  logic [3:0]       dp_len_bytes = '0;
  logic [63:0]      dp_left      = '0;
  logic [1:0]       dp_sidx      = '0;
  bit               dp_found     = 1'b0;
  logic [2:0]       cfg_active   = '0;
  logic [3:0][31:0] cfg_ids      = '0;

  dfr_result_t deframed_q [$];
  dir_row_t    dir_rows [DIR_ROWS];

  int errors       = 0;
  int bytes_in     = 0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int packets      = 0;
  int quiet        = 0;

  klv_essence_deframer_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_byte_i      (in_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (res_kind),
    .payload_byte_o (res_byte),
    .stream_sel_o   (res_sidx),
    .packet_end_o   (res_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [7:0] lead_byte(input int k);
    return ESSENCE_LEAD[8 * (PREFIX_LEN - 1 - k) +: 8];
  endfunction

  // Length field done: stream lookup, empty marker or unknown-stream stop
  function automatic void close_length(output bit has, output dfr_result_t r);
    int n;
    has = 1'b0;
    r   = '0;
    n   = (cfg_active > NUM_STREAMS) ? NUM_STREAMS : int'(cfg_active);
    if (!dp_is_ess) begin
      dp_state = (dp_left == 0) ? ST_KEY : ST_SKIP;
      return;
    end
    dp_found = 1'b0;
    dp_sidx  = '0;
    for (int k = n - 1; k >= 0; k--) begin
      if (cfg_ids[k] == dp_track) begin
        dp_found = 1'b1;
        dp_sidx  = 2'(k);
      end
    end
    if (!dp_found) begin
      dp_state = ST_HALT;
      has      = 1'b1;
      r.kind   = KIND_UNKNOWN;
    end else if (dp_left == 0) begin
      dp_state = ST_KEY;
      has      = 1'b1;
      r        = '{KIND_EMPTY, 8'h00, dp_sidx, 1'b1};
    end else begin
      dp_state = ST_BODY;
    end
  endfunction

  // Advance the deframer model by one accepted byte
  function automatic void deframe_byte(input logic [7:0] b, output bit has,
                                       output dfr_result_t r);
    has = 1'b0;
    r   = '0;
    case (dp_state)
      ST_KEY: begin
        if (dp_key_pos == 0) begin
          dp_is_ess = 1'b1;
          dp_track  = '0;
        end
        if (dp_key_pos < PREFIX_LEN && b != lead_byte(dp_key_pos)) dp_is_ess = 1'b0;
        if (dp_key_pos >= ID_START) dp_track = {dp_track[23:0], b};
        dp_key_pos++;
        if (dp_key_pos >= KEY_LEN) begin
          dp_key_pos = 0;
          dp_state   = ST_LEN0;
        end
      end
      ST_LEN0: begin
        dp_left = '0;
        if (!b[7]) begin
          dp_left = 64'(b[6:0]);
          close_length(has, r);
        end else if (b[6:0] > MAX_BER_BYTES) begin
          dp_state = ST_HALT;
          has      = 1'b1;
          r.kind   = KIND_BER_ERR;
        end else begin
          dp_len_bytes = b[3:0];
          if (dp_len_bytes == 0) close_length(has, r);
          else dp_state = ST_LEN_MORE;
        end
      end
      ST_LEN_MORE: begin
        dp_left      = {dp_left[55:0], b};
        dp_len_bytes = dp_len_bytes - 4'd1;
        if (dp_len_bytes == 0) close_length(has, r);
      end
      ST_BODY: begin
        dp_left = dp_left - 64'd1;
        if (dp_left == 0) dp_state = ST_KEY;
        has = 1'b1;
        r   = '{KIND_PAYLOAD, b, dp_sidx, dp_left == 0};
      end
      ST_SKIP: begin
        dp_left = dp_left - 64'd1;
        if (dp_left == 0) dp_state = ST_KEY;
      end
      default: begin
        dp_state = ST_HALT;
      end
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      errors++;
    end
  endfunction

  // Predict on accepted bytes, check accepted result items
  always @(posedge clk) begin : scoreboard
    bit          has;
    dfr_result_t r;
    dfr_result_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        deframe_byte(in_byte, has, r);
        bytes_in++;
        if (note_valid) deframed_q.push_back(note_r);
        else if (has) deframed_q.push_back(r);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (deframed_q.size() == 0) begin
          $display("%0t: result item kind %0d arrived with nothing expected", $time, res_kind);
          errors++;
        end else begin
          e = deframed_q.pop_front();
          check_field("result_kind", 32'(e.kind), 32'(res_kind));
          check_field("payload_byte", 32'(e.data), 32'(res_byte));
          check_field("stream_sel", 32'(e.sidx), 32'(res_sidx));
          check_field("packet_end", 32'(e.last), 32'(res_last));
        end
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet);
        $display("klv_essence_deframer_unit test failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin : drain
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one byte, optionally after a gap; returns at the accepting edge
  task automatic send_byte(input logic [7:0] b, input bit typed, input dfr_result_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    note_valid <= typed;
    note_r     <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Key, BER length and body of one packet; expectation rides on its last byte
  task automatic send_packet(input bit essence, input logic [31:0] track,
                             input int unsigned len, input int lcount, input int fill,
                             input bit typed, input dfr_result_t want);
    logic [7:0]  seq [$];
    logic [7:0]  kb;
    logic [63:0] lv;
    int          brk;
    bit          near;
    brk  = $urandom_range(0, PREFIX_LEN - 1);
    near = 1'($urandom_range(0, 1));
    lv   = 64'(len);
    for (int j = 0; j < KEY_LEN; j++) begin
      if (j < PREFIX_LEN && (essence || near)) kb = lead_byte(j);
      else kb = 8'($urandom);
      if (j >= ID_START) kb = track[8 * (KEY_LEN - 1 - j) +: 8];
      // a plain key differs from the lead in at least one byte
      if (!essence && j == brk) kb = lead_byte(j) ^ 8'($urandom_range(1, 255));
      seq.push_back(kb);
    end
    if (lcount < 0) begin
      seq.push_back({1'b0, lv[6:0]});
    end else begin
      seq.push_back({1'b1, lcount[6:0]});
      if (lcount <= MAX_BER_BYTES)
        for (int j = lcount - 1; j >= 0; j--) seq.push_back(lv[8 * j +: 8]);
    end
    if (lcount <= MAX_BER_BYTES)
      for (int j = 0; j < int'(len); j++) seq.push_back(fill < 0 ? 8'($urandom) : fill[7:0]);
    for (int j = 0; j < seq.size(); j++) send_byte(seq[j], typed && j == seq.size() - 1, want);
    packets++;
  endtask

  // Drop valid and wait until every expected item is out and the block is quiet
  task automatic settle(input int cycles);
    in_valid <= 1'b0;
    @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_ACTIVE) cfg_active = d[2:0];
    else if (idx <= CFG_STREAM_3) cfg_ids[2'(idx - 3'(CFG_STREAM_0))] = d;
  endtask

  task automatic program_streams(input logic [2:0] active, input logic [3:0][31:0] ids,
                                 input bit stray);
    cfg_write(CFG_ACTIVE, {29'd0, active});
    for (int k = 0; k < NUM_STREAMS; k++) cfg_write(3'(CFG_STREAM_0) + 3'(k), ids[k]);
    // index past the register list must be dropped
    if (stray) cfg_write(3'(CFG_STREAM_3) + 3'($urandom_range(1, 3)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [3:0][31:0] ids;
    logic [31:0]      bad_id;
    logic [31:0]      trk;
    int unsigned      len;
    int               lcount;
    int               n_act;
    int               start;
    int               roll;
    bit               essence;
    bit               hit;
    string            end_kind;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset no stream is active; a plain empty packet passes silently
    send_packet(1'b0, 32'h0, 0, SHORT_FORM, 0, 1'b0, '0);
    settle(SETTLE_CYCLES);
    ids[0] = 32'h0000_0000;
    ids[1] = 32'hffff_ffff;
    ids[2] = $urandom;
    ids[3] = $urandom;
    program_streams(3'd2, ids, 1'b0);

    // Directed packets: empty markers, one-byte bodies at both byte extremes, then plain and long-form packets
    dir_rows[0] = '{1'b1, 32'h0000_0000, 0, SHORT_FORM, 0, 1'b1,
                    '{KIND_EMPTY, 8'h00, 2'd0, 1'b1}};
    dir_rows[1] = '{1'b1, 32'hffff_ffff, 0, 0, 0, 1'b1,
                    '{KIND_EMPTY, 8'h00, 2'd1, 1'b1}};
    dir_rows[2] = '{1'b1, 32'hffff_ffff, 1, MAX_BER_BYTES, 255, 1'b1,
                    '{KIND_PAYLOAD, 8'hff, 2'd1, 1'b1}};
    dir_rows[3] = '{1'b1, 32'h0000_0000, 1, SHORT_FORM, 0, 1'b1,
                    '{KIND_PAYLOAD, 8'h00, 2'd0, 1'b1}};
    dir_rows[4] = '{1'b0, 32'h0000_0000, 3, SHORT_FORM, -1, 1'b0, '0};
    dir_rows[5] = '{1'b1, 32'h0000_0000, 6, 1, -1, 1'b0, '0};
    dir_rows[6] = '{1'b0, 32'hffff_ffff, 0, 2, 0, 1'b0, '0};
    for (int i = 0; i < DIR_ROWS; i++)
      send_packet(dir_rows[i].essence, dir_rows[i].track, dir_rows[i].len,
                  dir_rows[i].lcount, dir_rows[i].fill, dir_rows[i].typed, dir_rows[i].want);

    // Random phases, each under its own stream setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle(SETTLE_CYCLES);
      for (int k = 0; k < NUM_STREAMS; k++) ids[k] = $urandom;
      case (ph)
        0: begin
          program_streams(3'd4, ids, 1'b0);
          hold_req = 1'b1;
        end
        1: begin
          ids[0] = 32'h0000_0000;
          ids[1] = 32'hffff_ffff;
          program_streams(3'd7, ids, 1'b1);   // above the stream count
        end
        2: program_streams(3'd1, ids, 1'b1);
        3: program_streams(3'd0, ids, 1'b0);  // nothing active: plain packets only
        default: begin
          ids[2] = ids[1];                     // lowest index must win
          program_streams(3'd3, ids, 1'b0);
        end
      endcase
      n_act = (cfg_active > NUM_STREAMS) ? NUM_STREAMS : int'(cfg_active);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        idle_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        essence = (n_act != 0) && ($urandom_range(0, 9) < 7);
        trk     = essence ? cfg_ids[$urandom_range(0, n_act - 1)] : 32'($urandom);
        roll    = $urandom_range(0, 9);
        if (roll == 0) len = 0;
        else if (roll <= 6) len = $urandom_range(1, 12);
        else if (roll <= 8) len = $urandom_range(13, 127);
        else len = $urandom_range(128, 300);
        if (len < 128 && $urandom_range(0, 2) != 0) lcount = SHORT_FORM;
        else lcount = $urandom_range(len == 0 ? 0 : (len < 256 ? 1 : 2), MAX_BER_BYTES);
        send_packet(essence, trk, len, lcount, -1, 1'b0, '0);
      end
    end

    // Close with one of the two stopping errors
    n_act = (cfg_active > NUM_STREAMS) ? NUM_STREAMS : int'(cfg_active);
    if ($urandom_range(0, 1) == 1) begin
      end_kind = "length-field error";
      send_packet(1'($urandom_range(0, 1)), cfg_ids[0], 0,
                  $urandom_range(MAX_BER_BYTES + 1, 127),
                  0, 1'b1, '{KIND_BER_ERR, 8'h00, 2'd0, 1'b0});
    end else begin
      end_kind = "unknown-stream error";
      // prefer an id that is programmed but not active
      bad_id = ($urandom_range(0, 1) == 1) ? cfg_ids[NUM_STREAMS - 1] : 32'($urandom);
      do begin
        hit = 1'b0;
        for (int k = 0; k < n_act; k++) if (cfg_ids[k] == bad_id) hit = 1'b1;
        if (hit) bad_id = $urandom;
      end while (hit);
      send_packet(1'b1, bad_id, 0, ($urandom_range(0, 1) == 1) ? SHORT_FORM : 0, 0, 1'b1,
                  '{KIND_UNKNOWN, 8'h00, 2'd0, 1'b0});
    end

    // Halted: a valid packet and loose bytes must all be dropped
    send_packet(1'b1, cfg_ids[0], 4, SHORT_FORM, -1, 1'b0, '0);
    for (int i = 0; i < TAIL_BYTES; i++) send_byte(8'($urandom), 1'b0, '0);

    settle(END_CYCLES);
    $display("Sent %0d bytes in %0d packets across seven stream settings; %0d result items seen.",
             bytes_in, packets, results_seen);
    $display("Run ended on a %s, then bytes that the halted block had to drop.", end_kind);
    if (errors == 0) begin
      $display("klv_essence_deframer_unit test passed");
    end else begin
      $display("klv_essence_deframer_unit test failed");
    end
    $finish;
  end

endmodule
